// ===== rtl/scp_pkg.sv =====
`default_nettype none

package scp_pkg;

    // Selector: {crn, crm, opc2}
    localparam int SEL_W = 11;
    typedef logic [SEL_W-1:0] sel_key_t;

    localparam sel_key_t KEY_ID_MAIN = {4'd0, 4'd0, 3'd0};
    localparam sel_key_t KEY_ID_TCM  = {4'd0, 4'd0, 3'd1};
    localparam sel_key_t KEY_CTRL    = {4'd1, 4'd0, 3'd0};
    localparam sel_key_t KEY_DTCM    = {4'd9, 4'd1, 3'd0};
    localparam sel_key_t KEY_ITCM    = {4'd9, 4'd1, 3'd1};
    localparam sel_key_t KEY_HALT_A  = {4'd7, 4'd0, 3'd4};
    localparam sel_key_t KEY_HALT_B  = {4'd7, 4'd8, 3'd2};

    typedef enum logic [2:0] {
        SEL_ID_MAIN,
        SEL_ID_TCM,
        SEL_CTRL,
        SEL_DTCM,
        SEL_ITCM,
        SEL_HALT,
        SEL_NONE
    } sel_t;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [31:0] ID_MAIN_WORD  = 32'h4105_9461;
    localparam logic [31:0] ID_TCM_WORD   = 32'h0F0D_2112;
    localparam logic [31:0] CTRL_MASK     = 32'h000F_F085;
    localparam logic [31:0] CTRL_RESET    = 32'h0000_0078;
    localparam logic [31:0] REGION_MASK   = 32'hFFFF_F000;
    localparam logic [5:0]  TCM_BASE_LOG2 = 6'd9;
    localparam logic [5:0]  TCM_MIN_LOG2  = 6'd12;

    // Control word bit positions
    localparam int CTRL_VEC_HIGH = 13;
    localparam int CTRL_DTCM_EN  = 16;
    localparam int CTRL_DTCM_LD  = 17;
    localparam int CTRL_ITCM_EN  = 18;
    localparam int CTRL_ITCM_LD  = 19;

    typedef struct packed {
        logic        action;
        logic [3:0]  crn;
        logic [3:0]  crm;
        logic [2:0]  opc2;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        unknown_register;
        logic        remap_valid;
        logic [31:0] remap_start;
        logic [5:0]  remap_size_log2;
        logic        halt_request;
        logic        vectors_high;
        logic        dtcm_read_on;
        logic        dtcm_write_on;
        logic        itcm_read_on;
        logic        itcm_write_on;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] ctrl;
        logic [31:0] dtcm;
        logic [31:0] itcm;
    } regs_t;

    typedef struct packed {
        rsp_t  first;
        rsp_t  second;
        logic  two;
        regs_t regs_next;
    } decode_t;

endpackage

`default_nettype wire

// ===== rtl/scp_ifs.sv =====
`default_nettype none

interface scp_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  crn;
    logic [3:0]  crm;
    logic [2:0]  opc2;
    logic [31:0] write_data;

    modport source (output valid, action, crn, crm, opc2, write_data, input ready);
    modport sink   (input valid, action, crn, crm, opc2, write_data, output ready);
endinterface

interface scp_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        unknown_register;
    logic        remap_valid;
    logic [31:0] remap_start;
    logic [5:0]  remap_size_log2;
    logic        halt_request;
    logic        vectors_high;
    logic        dtcm_read_on;
    logic        dtcm_write_on;
    logic        itcm_read_on;
    logic        itcm_write_on;
    logic        last;

    modport source (
        output valid, read_data, unknown_register, remap_valid, remap_start,
               remap_size_log2, halt_request, vectors_high, dtcm_read_on,
               dtcm_write_on, itcm_read_on, itcm_write_on, last,
        input  ready
    );
    modport sink (
        input  valid, read_data, unknown_register, remap_valid, remap_start,
               remap_size_log2, halt_request, vectors_high, dtcm_read_on,
               dtcm_write_on, itcm_read_on, itcm_write_on, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/system_control_coprocessor_regs.sv =====
// System control coprocessor register block.
//
// req (sink): one coprocessor access per word: action (read/write), the
// selector crn/crm/opc2 and write_data. rsp (source): result words, each
// carrying read data, unknown/remap/halt indications, the flags derived
// from the control word after the access, and last on the access's final
// word.
// An accepted access sits in the input register and is decoded and
// written to the result buffer once that buffer drains; its first result
// word is offered straight from the buffer.
// Throughput: one access per cycle for accesses with one result word
// while rsp.ready stays high. Control and DTCM region writes make two
// words and fill the two-slot result buffer; the next access is decoded
// only once the buffer drains.
// Reset: control word returns to 0x00000078, both TCM region words to 0,
// input and result stages empty.
// Stall: when rsp.ready is low the result buffer holds; the input register
// then fills and req.ready drops until the buffer drains.
`default_nettype none

module system_control_coprocessor_regs (
    input  var logic  clk,
    input  var logic  rst_n,
    scp_req_if.sink   req,
    scp_rsp_if.source rsp
);

    scp_pkg::req_t    hold_reg;
    logic             hold_valid_reg;
    scp_pkg::regs_t   regs_reg;
    scp_pkg::decode_t dec;
    scp_pkg::rsp_t    head;
    logic             drained;
    logic             head_valid;
    logic             pop;
    logic             process;

    assign pop       = rsp.valid & rsp.ready;
    assign process   = hold_valid_reg & drained;
    assign req.ready = ~hold_valid_reg | process;

    // Input register: take a new word whenever the held one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (req.ready)
            hold_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            hold_reg.action     <= req.action;
            hold_reg.crn        <= req.crn;
            hold_reg.crm        <= req.crm;
            hold_reg.opc2       <= req.opc2;
            hold_reg.write_data <= req.write_data;
        end
    end

    scp_decode u_decode (
        .req  (hold_reg),
        .regs (regs_reg),
        .dec  (dec)
    );

    // Architectural registers change only when an access is decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.ctrl <= scp_pkg::CTRL_RESET;
            regs_reg.dtcm <= '0;
            regs_reg.itcm <= '0;
        end
        else if (process)
        begin
            regs_reg <= dec.regs_next;
        end
    end

    scp_rsp_queue u_rsp_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (process),
        .push_two    (dec.two),
        .push_first  (dec.first),
        .push_second (dec.second),
        .pop         (pop),
        .drained     (drained),
        .head_valid  (head_valid),
        .head        (head)
    );

    assign rsp.valid            = head_valid;
    assign rsp.read_data        = head.read_data;
    assign rsp.unknown_register = head.unknown_register;
    assign rsp.remap_valid      = head.remap_valid;
    assign rsp.remap_start      = head.remap_start;
    assign rsp.remap_size_log2  = head.remap_size_log2;
    assign rsp.halt_request     = head.halt_request;
    assign rsp.vectors_high     = head.vectors_high;
    assign rsp.dtcm_read_on     = head.dtcm_read_on;
    assign rsp.dtcm_write_on    = head.dtcm_write_on;
    assign rsp.itcm_read_on     = head.itcm_read_on;
    assign rsp.itcm_write_on    = head.itcm_write_on;
    assign rsp.last             = head.last;

    // A word without last always has its partner queued behind it
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.last |=> rsp.valid)
        else $error("second result word missing");

    a_remap_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.remap_valid |-> rsp.remap_size_log2 >= scp_pkg::TCM_MIN_LOG2)
        else $error("remap size below minimum");

    a_halt_alone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.halt_request |-> rsp.last && !rsp.remap_valid)
        else $error("halt word carries remap or is not last");

    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.unknown_register |-> rsp.read_data == 32'd0 && rsp.last)
        else $error("unknown selector returned data");

endmodule

`default_nettype wire

// ===== rtl/scp_decode.sv =====
`default_nettype none

module scp_decode (
    input  var scp_pkg::req_t    req,
    input  var scp_pkg::regs_t   regs,
    output var scp_pkg::decode_t dec
);

    function automatic logic [5:0] size_log2(input logic [31:0] word);
        logic [5:0] e;
        begin
            e = scp_pkg::TCM_BASE_LOG2 + {1'b0, word[5:1]};
            size_log2 = (e < scp_pkg::TCM_MIN_LOG2) ? scp_pkg::TCM_MIN_LOG2 : e;
        end
    endfunction

    scp_pkg::sel_t  sel;
    scp_pkg::regs_t nxt;
    scp_pkg::rsp_t  base;
    scp_pkg::rsp_t  r0;
    scp_pkg::rsp_t  r1;
    logic           two;
    logic [5:0]     itcm_old_sz;
    logic [5:0]     itcm_new_sz;

    always_comb
    begin
        unique case ({req.crn, req.crm, req.opc2})
            scp_pkg::KEY_ID_MAIN: sel = scp_pkg::SEL_ID_MAIN;
            scp_pkg::KEY_ID_TCM:  sel = scp_pkg::SEL_ID_TCM;
            scp_pkg::KEY_CTRL:    sel = scp_pkg::SEL_CTRL;
            scp_pkg::KEY_DTCM:    sel = scp_pkg::SEL_DTCM;
            scp_pkg::KEY_ITCM:    sel = scp_pkg::SEL_ITCM;
            scp_pkg::KEY_HALT_A:  sel = scp_pkg::SEL_HALT;
            scp_pkg::KEY_HALT_B:  sel = scp_pkg::SEL_HALT;
            default:              sel = scp_pkg::SEL_NONE;
        endcase
    end

    // Next register state
    always_comb
    begin
        nxt = regs;
        if (req.action == scp_pkg::ACT_WRITE)
        begin
            case (sel)
                scp_pkg::SEL_CTRL:
                    nxt.ctrl = (regs.ctrl & ~scp_pkg::CTRL_MASK)
                             | (req.write_data & scp_pkg::CTRL_MASK);
                scp_pkg::SEL_DTCM: nxt.dtcm = req.write_data;
                scp_pkg::SEL_ITCM: nxt.itcm = req.write_data;
                default:           nxt = regs;
            endcase
        end
    end

    assign itcm_old_sz = size_log2(regs.itcm);
    assign itcm_new_sz = size_log2(req.write_data);

    // Flags come from the control word as it stands after the access
    always_comb
    begin
        base = '0;
        base.vectors_high  = nxt.ctrl[scp_pkg::CTRL_VEC_HIGH];
        base.dtcm_write_on = nxt.ctrl[scp_pkg::CTRL_DTCM_EN];
        base.dtcm_read_on  = nxt.ctrl[scp_pkg::CTRL_DTCM_EN] & ~nxt.ctrl[scp_pkg::CTRL_DTCM_LD];
        base.itcm_write_on = nxt.ctrl[scp_pkg::CTRL_ITCM_EN];
        base.itcm_read_on  = nxt.ctrl[scp_pkg::CTRL_ITCM_EN] & ~nxt.ctrl[scp_pkg::CTRL_ITCM_LD];
    end

    always_comb
    begin
        r0 = base;
        r1 = base;
        r1.last = 1'b1;
        two = 1'b0;
        if (req.action == scp_pkg::ACT_READ)
        begin
            r0.last = 1'b1;
            case (sel)
                scp_pkg::SEL_ID_MAIN: r0.read_data = scp_pkg::ID_MAIN_WORD;
                scp_pkg::SEL_ID_TCM:  r0.read_data = scp_pkg::ID_TCM_WORD;
                scp_pkg::SEL_CTRL:    r0.read_data = regs.ctrl;
                scp_pkg::SEL_DTCM:    r0.read_data = regs.dtcm;
                scp_pkg::SEL_ITCM:    r0.read_data = regs.itcm;
                default:              r0.unknown_register = 1'b1;
            endcase
        end
        else
        begin
            case (sel)
                scp_pkg::SEL_CTRL:
                begin
                    two = 1'b1;
                    r0.remap_valid     = 1'b1;
                    r0.remap_start     = regs.dtcm & scp_pkg::REGION_MASK;
                    r0.remap_size_log2 = size_log2(regs.dtcm);
                    r1.remap_valid     = 1'b1;
                    r1.remap_size_log2 = itcm_old_sz;
                end
                scp_pkg::SEL_DTCM:
                begin
                    two = 1'b1;
                    r0.remap_valid     = 1'b1;
                    r0.remap_start     = regs.dtcm & scp_pkg::REGION_MASK;
                    r0.remap_size_log2 = size_log2(regs.dtcm);
                    r1.remap_valid     = 1'b1;
                    r1.remap_start     = req.write_data & scp_pkg::REGION_MASK;
                    r1.remap_size_log2 = size_log2(req.write_data);
                end
                scp_pkg::SEL_ITCM:
                begin
                    r0.last            = 1'b1;
                    r0.remap_valid     = 1'b1;
                    r0.remap_size_log2 = (itcm_old_sz > itcm_new_sz) ? itcm_old_sz
                                                                      : itcm_new_sz;
                end
                scp_pkg::SEL_HALT:
                begin
                    r0.last         = 1'b1;
                    r0.halt_request = 1'b1;
                end
                default:
                begin
                    r0.last             = 1'b1;
                    r0.unknown_register = 1'b1;
                end
            endcase
        end
    end

    assign dec.first     = r0;
    assign dec.second    = r1;
    assign dec.two       = two;
    assign dec.regs_next = nxt;

endmodule

`default_nettype wire

// ===== rtl/scp_rsp_queue.sv =====
`default_nettype none

module scp_rsp_queue (
    input  var logic          clk,
    input  var logic          rst_n,
    input  var logic          push,
    input  var logic          push_two,
    input  var scp_pkg::rsp_t push_first,
    input  var scp_pkg::rsp_t push_second,
    input  var logic          pop,
    output var logic          drained,
    output var logic          head_valid,
    output var scp_pkg::rsp_t head
);

    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic [1:0]    cnt_after_pop;
    scp_pkg::rsp_t slot0_reg;
    scp_pkg::rsp_t slot1_reg;

    assign cnt_after_pop = cnt_reg - {1'b0, pop};
    assign drained       = (cnt_after_pop == 2'd0);
    assign head_valid    = (cnt_reg != 2'd0);
    assign head          = slot0_reg;

    always_comb
    begin
        if (push)
            cnt_next = push_two ? 2'd2 : 2'd1;
        else
            cnt_next = cnt_after_pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // Load both slots on push; otherwise advance the second word on pop
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot0_reg <= push_first;
            slot1_reg <= push_second;
        end
        else if (pop)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_system_control_coprocessor_regs.sv =====
`timescale 1ns / 100ps

module tb_system_control_coprocessor_regs;
    import scp_pkg::*;

    // Selectors that name no register: the top corner and a gap next to the ID words
    localparam sel_key_t KEY_OUTSIDE_TOP = {4'd15, 4'd15, 3'd7};
    localparam sel_key_t KEY_OUTSIDE_LOW = {4'd0, 4'd0, 3'd2};

    localparam int N_PROBES     = 25;
    localparam int N_RANDOM     = 680;
    localparam int DRAIN_AT     = 250;
    localparam int STEADY_FROM  = 300;
    localparam int STEADY_UNTIL = 450;
    localparam int IDLE_PCT     = 18;
    localparam int SETTLE_CYC   = 4;

    // One row of the directed table. When typed is set, the first result word
    // must carry typed_data / typed_unknown; everything else comes from the
    // register shadow below.
    typedef struct {
        logic        act;
        sel_key_t    key;
        logic [31:0] data;
        bit          typed;
        logic [31:0] typed_data;
        logic        typed_unknown;
    } probe_row_t;

    logic clk = 1'b0;
    logic rst_n;

    scp_req_if req_ch ();
    scp_rsp_if rsp_ch ();

    system_control_coprocessor_regs dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the three architectural registers
    logic [31:0] ctl_reg  = CTRL_RESET;
    logic [31:0] dtcm_reg = '0;
    logic [31:0] itcm_reg = '0;

    // Result words still owed by the block, oldest first
    rsp_t pending_rsp_words[$];

    int  mismatch_count = 0;
    int  reads_sent     = 0;
    int  writes_sent    = 0;
    int  remap_words    = 0;
    int  halt_words     = 0;
    int  unknown_words  = 0;
    // High while both sides run without any idling or stalling
    bit  steady_run     = 1'b0;

    probe_row_t probe_rows [N_PROBES] = '{
        // reset values and the fixed ID words
        '{ACT_READ,  KEY_ID_MAIN,     32'h0000_0000, 1'b1, 32'h4105_9461, 1'b0},
        '{ACT_READ,  KEY_ID_TCM,      32'hFFFF_FFFF, 1'b1, 32'h0F0D_2112, 1'b0},
        '{ACT_READ,  KEY_CTRL,        32'h0000_0000, 1'b1, 32'h0000_0078, 1'b0},
        '{ACT_READ,  KEY_DTCM,        32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{ACT_READ,  KEY_ITCM,        32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        // writes to read-only IDs, reads of halt selectors, dead selectors
        '{ACT_WRITE, KEY_ID_MAIN,     32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
        '{ACT_READ,  KEY_HALT_A,      32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{ACT_READ,  KEY_HALT_B,      32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{ACT_READ,  KEY_OUTSIDE_TOP, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{ACT_WRITE, KEY_OUTSIDE_TOP, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b1},
        // both halt selectors
        '{ACT_WRITE, KEY_HALT_A,      32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
        '{ACT_WRITE, KEY_HALT_B,      32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
        // control word under its mask, all ones then all zeros
        '{ACT_WRITE, KEY_CTRL,        32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        '{ACT_READ,  KEY_CTRL,        32'h0000_0000, 1'b1, 32'h000F_F0FD, 1'b0},
        '{ACT_WRITE, KEY_CTRL,        32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
        '{ACT_READ,  KEY_CTRL,        32'h0000_0000, 1'b1, 32'h0000_0078, 1'b0},
        // both TCMs enabled outside load mode
        '{ACT_WRITE, KEY_CTRL,        32'h0005_0000, 1'b0, 32'h0000_0000, 1'b0},
        // region words: largest size, then sizes below and at the clamp
        '{ACT_WRITE, KEY_DTCM,        32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        '{ACT_READ,  KEY_DTCM,        32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{ACT_WRITE, KEY_DTCM,        32'h0000_0004, 1'b0, 32'h0000_0000, 1'b0},
        '{ACT_WRITE, KEY_ITCM,        32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
        '{ACT_WRITE, KEY_ITCM,        32'h0000_0006, 1'b0, 32'h0000_0000, 1'b0},
        // load modes on both TCMs, high vectors
        '{ACT_WRITE, KEY_CTRL,        32'h000F_2000, 1'b0, 32'h0000_0000, 1'b0},
        '{ACT_READ,  KEY_OUTSIDE_LOW, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{ACT_READ,  KEY_ITCM,        32'h0000_0000, 1'b1, 32'h0000_0006, 1'b0}
    };

    // ------------------------------------------------------------------
    // Register shadow and result prediction
    // ------------------------------------------------------------------

    // Size exponent of a TCM region word, clamped at the low end
    function automatic logic [5:0] tcm_exp(input logic [31:0] region);
        logic [5:0] e;
        e = TCM_BASE_LOG2 + {1'b0, region[5:1]};
        return (e < TCM_MIN_LOG2) ? TCM_MIN_LOG2 : e;
    endfunction

    // Build one result word; the flags follow the shadow control word as it
    // stands at the time of the call.
    function automatic rsp_t make_word(input logic [31:0] rd, input logic unk,
                                       input logic rv, input logic [31:0] start,
                                       input logic [5:0] sz, input logic halt,
                                       input logic fin);
        rsp_t w;
        w.read_data        = rd;
        w.unknown_register = unk;
        w.remap_valid      = rv;
        w.remap_start      = rv ? start : 32'h0;
        w.remap_size_log2  = rv ? sz : 6'd0;
        w.halt_request     = halt;
        w.vectors_high     = ctl_reg[CTRL_VEC_HIGH];
        w.dtcm_read_on     = ctl_reg[CTRL_DTCM_EN] & ~ctl_reg[CTRL_DTCM_LD];
        w.dtcm_write_on    = ctl_reg[CTRL_DTCM_EN];
        w.itcm_read_on     = ctl_reg[CTRL_ITCM_EN] & ~ctl_reg[CTRL_ITCM_LD];
        w.itcm_write_on    = ctl_reg[CTRL_ITCM_EN];
        w.last             = fin;
        return w;
    endfunction

    // Apply one access to the shadow and return the one or two words it owes
    task automatic predict_access(input req_t a, output rsp_t w0, output rsp_t w1,
                                  output int count);
        sel_key_t   key;
        logic [5:0] old_sz;
        logic [5:0] new_sz;
        key   = {a.crn, a.crm, a.opc2};
        w1    = '0;
        count = 1;
        if (a.action == ACT_READ) begin
            case (key)
                KEY_ID_MAIN: w0 = make_word(ID_MAIN_WORD, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                KEY_ID_TCM:  w0 = make_word(ID_TCM_WORD, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                KEY_CTRL:    w0 = make_word(ctl_reg, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                KEY_DTCM:    w0 = make_word(dtcm_reg, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                KEY_ITCM:    w0 = make_word(itcm_reg, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1);
                default:     w0 = make_word('0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b1);
            endcase
        end
        else begin
            case (key)
                KEY_CTRL:
                begin
                    // update first: both remap words carry the new flags
                    ctl_reg = (ctl_reg & ~CTRL_MASK) | (a.write_data & CTRL_MASK);
                    w0 = make_word('0, 1'b0, 1'b1, dtcm_reg & REGION_MASK,
                                   tcm_exp(dtcm_reg), 1'b0, 1'b0);
                    w1 = make_word('0, 1'b0, 1'b1, '0, tcm_exp(itcm_reg), 1'b0, 1'b1);
                    count = 2;
                end
                KEY_DTCM:
                begin
                    // old region first, then the new one
                    w0 = make_word('0, 1'b0, 1'b1, dtcm_reg & REGION_MASK,
                                   tcm_exp(dtcm_reg), 1'b0, 1'b0);
                    dtcm_reg = a.write_data;
                    w1 = make_word('0, 1'b0, 1'b1, dtcm_reg & REGION_MASK,
                                   tcm_exp(dtcm_reg), 1'b0, 1'b1);
                    count = 2;
                end
                KEY_ITCM:
                begin
                    // one refresh at address 0 covering the larger of old and new
                    old_sz   = tcm_exp(itcm_reg);
                    itcm_reg = a.write_data;
                    new_sz   = tcm_exp(itcm_reg);
                    w0 = make_word('0, 1'b0, 1'b1, '0,
                                   (old_sz > new_sz) ? old_sz : new_sz, 1'b0, 1'b1);
                end
                KEY_HALT_A, KEY_HALT_B:
                    w0 = make_word('0, 1'b0, 1'b0, '0, '0, 1'b1, 1'b1);
                default:
                    w0 = make_word('0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b1);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, want %h", name, got, want));
    endtask

    // Compare one accepted result word against the oldest owed word
    task automatic check_result_word();
        rsp_t got;
        rsp_t want;
        got.read_data        = rsp_ch.read_data;
        got.unknown_register = rsp_ch.unknown_register;
        got.remap_valid      = rsp_ch.remap_valid;
        got.remap_start      = rsp_ch.remap_start;
        got.remap_size_log2  = rsp_ch.remap_size_log2;
        got.halt_request     = rsp_ch.halt_request;
        got.vectors_high     = rsp_ch.vectors_high;
        got.dtcm_read_on     = rsp_ch.dtcm_read_on;
        got.dtcm_write_on    = rsp_ch.dtcm_write_on;
        got.itcm_read_on     = rsp_ch.itcm_read_on;
        got.itcm_write_on    = rsp_ch.itcm_write_on;
        got.last             = rsp_ch.last;
        if (pending_rsp_words.size() == 0) begin
            report_mismatch("result word arrived with nothing owed");
        end
        else begin
            want = pending_rsp_words.pop_front();
            check_field("read_data", got.read_data, want.read_data);
            check_field("unknown_register", 32'(got.unknown_register),
                        32'(want.unknown_register));
            check_field("remap_valid", 32'(got.remap_valid), 32'(want.remap_valid));
            check_field("remap_start", got.remap_start, want.remap_start);
            check_field("remap_size_log2", 32'(got.remap_size_log2),
                        32'(want.remap_size_log2));
            check_field("halt_request", 32'(got.halt_request), 32'(want.halt_request));
            check_field("vectors_high", 32'(got.vectors_high), 32'(want.vectors_high));
            check_field("dtcm_read_on", 32'(got.dtcm_read_on), 32'(want.dtcm_read_on));
            check_field("dtcm_write_on", 32'(got.dtcm_write_on), 32'(want.dtcm_write_on));
            check_field("itcm_read_on", 32'(got.itcm_read_on), 32'(want.itcm_read_on));
            check_field("itcm_write_on", 32'(got.itcm_write_on), 32'(want.itcm_write_on));
            check_field("last", 32'(got.last), 32'(want.last));
        end
        remap_words   += int'(got.remap_valid);
        halt_words    += int'(got.halt_request);
        unknown_words += int'(got.unknown_register);
    endtask

    // Result side: sample the handshake as it stood before this edge, then
    // pick the next ready level. Stall at random except in the steady stretch.
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_result_word();
        rsp_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Access side
    // ------------------------------------------------------------------

    // Offer one access word and hold it until accepted; on acceptance run it
    // through the shadow and queue the words it owes. Called at a rising edge.
    task automatic offer_access(input req_t a, input bit typed,
                                input logic [31:0] typed_data, input logic typed_unknown);
        rsp_t w0;
        rsp_t w1;
        int   n;
        req_ch.valid      <= 1'b1;
        req_ch.action     <= a.action;
        req_ch.crn        <= a.crn;
        req_ch.crm        <= a.crm;
        req_ch.opc2       <= a.opc2;
        req_ch.write_data <= a.write_data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_access(a, w0, w1, n);
        // directed rows with a known answer override read data and the flag
        if (typed) begin
            w0.read_data        = typed_data;
            w0.unknown_register = typed_unknown;
        end
        pending_rsp_words.push_back(w0);
        if (n == 2)
            pending_rsp_words.push_back(w1);
        if (a.action == ACT_WRITE)
            writes_sent++;
        else
            reads_sent++;
    endtask

    // Drop valid for a random number of cycles, never in the steady stretch
    task automatic sender_gap();
        while (!steady_run && ($urandom_range(99) < IDLE_PCT)) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold off the next access until every owed word is back, then let the
    // pipeline settle
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_rsp_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Mostly well-formed accesses to live registers; the rest go to random
    // selectors. Data favors the all-ones and all-zeros extremes now and then.
    function automatic req_t random_access();
        req_t     a;
        sel_key_t key;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 14)
            key = KEY_CTRL;
        else if (pick < 28)
            key = KEY_DTCM;
        else if (pick < 42)
            key = KEY_ITCM;
        else if (pick < 52)
            key = KEY_ID_MAIN;
        else if (pick < 60)
            key = KEY_ID_TCM;
        else if (pick < 68)
            key = KEY_HALT_A;
        else if (pick < 76)
            key = KEY_HALT_B;
        else
            key = sel_key_t'($urandom_range(2 ** SEL_W - 1));
        a.action = ($urandom_range(99) < 55) ? ACT_WRITE : ACT_READ;
        {a.crn, a.crm, a.opc2} = key;
        pick = $urandom_range(9);
        if (pick == 0)
            a.write_data = 32'hFFFF_FFFF;
        else if (pick == 1)
            a.write_data = 32'h0;
        else
            a.write_data = $urandom;
        return a;
    endfunction

    // Drive every access input to a known value from time zero, release reset
    // once, then walk the directed table and the random part
    initial begin
        req_t a;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.action     <= ACT_READ;
        req_ch.crn        <= '0;
        req_ch.crm        <= '0;
        req_ch.opc2       <= '0;
        req_ch.write_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset values, extremes, dead selectors, every op
        for (int i = 0; i < N_PROBES; i++) begin
            a.action = probe_rows[i].act;
            {a.crn, a.crm, a.opc2} = probe_rows[i].key;
            a.write_data = probe_rows[i].data;
            offer_access(a, probe_rows[i].typed, probe_rows[i].typed_data,
                         probe_rows[i].typed_unknown);
            sender_gap();
        end
        drain_results();

        // Random part; one full drain partway, one stretch with no idling
        for (int i = 0; i < N_RANDOM; i++) begin
            steady_run = (i >= STEADY_FROM) && (i < STEADY_UNTIL);
            offer_access(random_access(), 1'b0, '0, 1'b0);
            if (i == DRAIN_AT)
                drain_results();
            else
                sender_gap();
        end
        steady_run = 1'b0;
        drain_results();

        $display("covered %0d directed and %0d random accesses (%0d reads, %0d writes)",
                 N_PROBES, N_RANDOM, reads_sent, writes_sent);
        $display("seen %0d remap words, %0d halt words, %0d unknown-selector words",
                 remap_words, halt_words, unknown_words);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("timeout with %0d words still owed", pending_rsp_words.size());
        $display("FAIL");
        $finish;
    end

endmodule
